### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/bir_pkg.sv
// ---------------------------------------------------------------------------
// bir_pkg
// types and constants of the bilinear image resizer
// ---------------------------------------------------------------------------
package bir_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int SIZE_REG_W = 10;
    localparam int SCALE_W    = 24;
    localparam int POS_W      = 12;
    localparam int CHAN_W     = 8;

    // weight operand: up to 1.0 in Q16
    localparam int WGT_W = 17;
    // multiply-accumulate: 17 x 24 product, result below 2^41
    localparam int ACC_W = 41;

    localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [SIZE_REG_W-1:0] SRC_WIDTH_RST  = 10'd512;
    localparam logic [SIZE_REG_W-1:0] SRC_HEIGHT_RST = 10'd512;
    localparam logic [SCALE_W-1:0]    INV_SCALE_RST  = 24'd46811;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH   = 2'd0,
        CFG_SRC_HEIGHT  = 2'd1,
        CFG_INV_SCALE_X = 2'd2,
        CFG_INV_SCALE_Y = 2'd3
    } t_cfg_idx;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAPX,
        S_MAPY,
        S_MAPD,
        S_RD00,
        S_RD01,
        S_RD10,
        S_RD11,
        S_BLT,
        S_BLY0,
        S_BLY1,
        S_DONE
    } t_state;

endpackage

### src/bilinear_image_resize_top.sv
// ---------------------------------------------------------------------------
// bilinear_image_resize_top
// rgb frame store with bilinear resampling on a shared multiply-accumulate
// ---------------------------------------------------------------------------
// usage
//   input channel (i_valid / o_ready): one transfer per item. req_type write
//   stores an rgb pixel at (pos_x, pos_y); req_type read asks for the output
//   pixel at (pos_x, pos_y), mapped to the source with q8.16 scale factors.
//   output channel (o_valid / i_ready): one result transfer per item, colors
//   zero on writes, status high when a write falls outside the source size.
//   config port: i_cfg_we with i_cfg_addr / i_cfg_data, written while idle.
// sequence
//   write: accepted, the done state then loads the output register, and the
//   next item is taken once it is loaded. read: sequencer steps map x and y
//   (2 mapping products), read 4 pixels through the one memory read port, then
//   blend on the 3-lane mac; the next item is taken once its result is loaded
// reset
//   config returns to 512 x 512 and scale 46811; the frame store is not
//   cleared, an unwritten pixel reads back as anything
// stall
//   a result waiting on i_ready holds the output register; the block still
//   accepts one new item and parks its result until the register frees
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bilinear_image_resize_top #(
    parameter int MAX_WIDTH  = bir_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bir_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [bir_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [bir_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_req_type,
    input  logic [bir_pkg::POS_W-1:0]       i_pos_x,
    input  logic [bir_pkg::POS_W-1:0]       i_pos_y,
    input  logic [bir_pkg::CHAN_W-1:0]      i_in_red,
    input  logic [bir_pkg::CHAN_W-1:0]      i_in_green,
    input  logic [bir_pkg::CHAN_W-1:0]      i_in_blue,
    // output channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bir_pkg::CHAN_W-1:0]      o_out_red,
    output logic [bir_pkg::CHAN_W-1:0]      o_out_green,
    output logic [bir_pkg::CHAN_W-1:0]      o_out_blue,
    output logic                            o_status
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int IW    = (XW > YW) ? XW : YW;
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SZW   = $clog2(MAXD + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PIX_W = 3 * bir_pkg::CHAN_W;
    localparam int CW    = bir_pkg::CHAN_W;
    localparam int BW    = bir_pkg::SCALE_W;
    localparam int AC    = bir_pkg::ACC_W;

    // config registers
    logic [bir_pkg::SIZE_REG_W-1:0] r_src_width, r_src_height;
    logic [bir_pkg::SCALE_W-1:0]    r_inv_scale_x, r_inv_scale_y;

    // sequencer and item registers
    bir_pkg::t_state          r_state, n_state;
    logic                     r_req;
    logic [bir_pkg::POS_W-1:0] r_pos_x, r_pos_y;
    logic                     r_status;
    logic [XW-1:0]            r_x0, r_x1;
    logic [YW-1:0]            r_y0, r_y1;
    logic [15:0]              r_fx, r_fy;

    // frame memory
    logic [PIX_W-1:0]         r_mem [DEPTH];
    logic [PIX_W-1:0]         r_rd;

    // mac lanes: red, green, blue
    logic [AC-1:0]            r_acc [3];
    logic [BW-1:0]            r_top [3];
    logic [BW-1:0]            r_bot [3];

    // output register
    logic                     r_out_valid;
    logic [CW-1:0]            r_out_red, r_out_green, r_out_blue;
    logic                     r_out_status;

    // ------------------------------------------------------------------
    // sizes in use, saturated to 1..max
    // ------------------------------------------------------------------
    logic [SZW-1:0] w_use, h_use;

    always_comb begin
        if (r_src_width == '0) begin
            w_use = SZW'(1);
        end else if (32'(r_src_width) > 32'(MAX_WIDTH)) begin
            w_use = SZW'(MAX_WIDTH);
        end else begin
            w_use = SZW'(r_src_width);
        end
        if (r_src_height == '0) begin
            h_use = SZW'(1);
        end else if (32'(r_src_height) > 32'(MAX_HEIGHT)) begin
            h_use = SZW'(MAX_HEIGHT);
        end else begin
            h_use = SZW'(r_src_height);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width   <= bir_pkg::SRC_WIDTH_RST;
            r_src_height  <= bir_pkg::SRC_HEIGHT_RST;
            r_inv_scale_x <= bir_pkg::INV_SCALE_RST;
            r_inv_scale_y <= bir_pkg::INV_SCALE_RST;
        end else if (i_cfg_we) begin
            case (bir_pkg::t_cfg_idx'(i_cfg_addr))
                bir_pkg::CFG_SRC_WIDTH:   r_src_width   <= i_cfg_data[bir_pkg::SIZE_REG_W-1:0];
                bir_pkg::CFG_SRC_HEIGHT:  r_src_height  <= i_cfg_data[bir_pkg::SIZE_REG_W-1:0];
                bir_pkg::CFG_INV_SCALE_X: r_inv_scale_x <= i_cfg_data[bir_pkg::SCALE_W-1:0];
                bir_pkg::CFG_INV_SCALE_Y: r_inv_scale_y <= i_cfg_data[bir_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input transfer and write range check
    // ------------------------------------------------------------------
    logic in_xfer, wr_ok, out_free;

    assign in_xfer  = i_valid && o_ready;
    assign wr_ok    = (32'(i_pos_x) < 32'(w_use)) && (32'(i_pos_y) < 32'(h_use));
    assign out_free = !r_out_valid || i_ready;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            bir_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_req_type == bir_pkg::REQ_READ) ? bir_pkg::S_MAPX
                                                                : bir_pkg::S_DONE;
                end
            end
            bir_pkg::S_MAPX: n_state = bir_pkg::S_MAPY;
            bir_pkg::S_MAPY: n_state = bir_pkg::S_MAPD;
            bir_pkg::S_MAPD: n_state = bir_pkg::S_RD00;
            bir_pkg::S_RD00: n_state = bir_pkg::S_RD01;
            bir_pkg::S_RD01: n_state = bir_pkg::S_RD10;
            bir_pkg::S_RD10: n_state = bir_pkg::S_RD11;
            bir_pkg::S_RD11: n_state = bir_pkg::S_BLT;
            bir_pkg::S_BLT:  n_state = bir_pkg::S_BLY0;
            bir_pkg::S_BLY0: n_state = bir_pkg::S_BLY1;
            bir_pkg::S_BLY1: n_state = bir_pkg::S_DONE;
            bir_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = bir_pkg::S_IDLE;
                end
            end
            default: n_state = bir_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer outputs: mac operands, read address, handshake
    // ------------------------------------------------------------------
    logic [bir_pkg::WGT_W-1:0] c_a;
    logic [BW-1:0]             c_b [3];
    logic                      c_en, c_clr;
    logic                      rd_hi_x, rd_hi_y;
    logic [bir_pkg::WGT_W-1:0] wx0, wy0;

    assign wx0 = bir_pkg::ONE_Q16 - {1'b0, r_fx};
    assign wy0 = bir_pkg::ONE_Q16 - {1'b0, r_fy};

    always_comb begin
        c_a     = '0;
        c_en    = 1'b0;
        c_clr   = 1'b0;
        rd_hi_x = 1'b0;
        rd_hi_y = 1'b0;
        o_ready = 1'b0;
        for (int l = 0; l < 3; l++) begin
            c_b[l] = '0;
        end
        case (r_state)
            bir_pkg::S_IDLE: o_ready = 1'b1;
            bir_pkg::S_MAPX: begin
                // horizontal source position, q16
                c_a    = bir_pkg::WGT_W'(r_pos_x);
                c_b[0] = r_inv_scale_x;
                c_en   = 1'b1;
                c_clr  = 1'b1;
            end
            bir_pkg::S_MAPY: begin
                c_a    = bir_pkg::WGT_W'(r_pos_y);
                c_b[0] = r_inv_scale_y;
                c_en   = 1'b1;
                c_clr  = 1'b1;
            end
            bir_pkg::S_RD00: ;
            bir_pkg::S_RD01: begin
                // rd holds top-left
                rd_hi_x = 1'b1;
                c_a     = wx0;
                c_en    = 1'b1;
                c_clr   = 1'b1;
                for (int l = 0; l < 3; l++) begin
                    c_b[l] = BW'(r_rd[PIX_W-1-CW*l -: CW]);
                end
            end
            bir_pkg::S_RD10: begin
                // rd holds top-right, acc becomes top row blend
                rd_hi_y = 1'b1;
                c_a     = {1'b0, r_fx};
                c_en    = 1'b1;
                for (int l = 0; l < 3; l++) begin
                    c_b[l] = BW'(r_rd[PIX_W-1-CW*l -: CW]);
                end
            end
            bir_pkg::S_RD11: begin
                rd_hi_x = 1'b1;
                rd_hi_y = 1'b1;
                c_a     = wx0;
                c_en    = 1'b1;
                c_clr   = 1'b1;
                for (int l = 0; l < 3; l++) begin
                    c_b[l] = BW'(r_rd[PIX_W-1-CW*l -: CW]);
                end
            end
            bir_pkg::S_BLT: begin
                c_a  = {1'b0, r_fx};
                c_en = 1'b1;
                for (int l = 0; l < 3; l++) begin
                    c_b[l] = BW'(r_rd[PIX_W-1-CW*l -: CW]);
                end
            end
            bir_pkg::S_BLY0: begin
                c_a   = wy0;
                c_en  = 1'b1;
                c_clr = 1'b1;
                for (int l = 0; l < 3; l++) begin
                    c_b[l] = r_top[l];
                end
            end
            bir_pkg::S_BLY1: begin
                c_a  = {1'b0, r_fy};
                c_en = 1'b1;
                for (int l = 0; l < 3; l++) begin
                    c_b[l] = r_bot[l];
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // coordinate mapping from the lane 0 product
    // ------------------------------------------------------------------
    logic [SZW-1:0]  m_sz;
    logic [AC-17:0]  m_ip;
    logic [IW-1:0]   m_idx, m_nxt;
    logic [15:0]     m_frac;

    always_comb begin
        m_sz = (r_state == bir_pkg::S_MAPY) ? w_use : h_use;
        m_ip = r_acc[0][AC-1:16];
        if (32'(m_ip) >= 32'(m_sz)) begin
            // past the edge: last column or row, no fraction
            m_idx  = IW'(m_sz - SZW'(1));
            m_frac = '0;
        end else begin
            m_idx  = IW'(m_ip);
            m_frac = r_acc[0][15:0];
        end
        // neighbour clamped to the last column or row
        m_nxt = (32'(m_idx) + 32'd1 < 32'(m_sz)) ? IW'(m_idx + IW'(1)) : m_idx;
    end

    // ------------------------------------------------------------------
    // item registers and sequencer state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bir_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req    <= i_req_type;
            r_pos_x  <= i_pos_x;
            r_pos_y  <= i_pos_y;
            r_status <= (i_req_type == bir_pkg::REQ_WRITE) && !wr_ok;
        end
        if (r_state == bir_pkg::S_MAPY) begin
            r_x0 <= m_idx[XW-1:0];
            r_x1 <= m_nxt[XW-1:0];
            r_fx <= m_frac;
        end
        if (r_state == bir_pkg::S_MAPD) begin
            r_y0 <= m_idx[YW-1:0];
            r_y1 <= m_nxt[YW-1:0];
            r_fy <= m_frac;
        end
    end

    // ------------------------------------------------------------------
    // frame memory, one write port and one read port
    // ------------------------------------------------------------------
    logic [AW-1:0] wr_addr, rd_addr;
    logic [XW-1:0] rd_x;
    logic [YW-1:0] rd_y;

    assign rd_x    = rd_hi_x ? r_x1 : r_x0;
    assign rd_y    = rd_hi_y ? r_y1 : r_y0;
    assign rd_addr = AW'(32'(rd_y) * MAX_WIDTH) + AW'(rd_x);
    assign wr_addr = AW'(32'(i_pos_y[YW-1:0]) * MAX_WIDTH) + AW'(i_pos_x[XW-1:0]);

    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_req_type == bir_pkg::REQ_WRITE) && wr_ok) begin
            r_mem[wr_addr] <= {i_in_red, i_in_green, i_in_blue};
        end
        r_rd <= r_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // shared multiply-accumulate, one lane per channel
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            if (c_en) begin
                r_acc[l] <= (c_clr ? '0 : r_acc[l]) + AC'(c_a) * AC'(c_b[l]);
            end
        end
        // row blends fit 24 bits: weights sum to one in q16
        if (r_state == bir_pkg::S_RD11) begin
            for (int l = 0; l < 3; l++) begin
                r_top[l] <= r_acc[l][BW-1:0];
            end
        end
        if (r_state == bir_pkg::S_BLY0) begin
            for (int l = 0; l < 3; l++) begin
                r_bot[l] <= r_acc[l][BW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic out_load;

    assign out_load = (r_state == bir_pkg::S_DONE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            if (r_req == bir_pkg::REQ_READ) begin
                // q32 result, keep the integer byte
                r_out_red   <= r_acc[0][39:32];
                r_out_green <= r_acc[1][39:32];
                r_out_blue  <= r_acc[2][39:32];
            end else begin
                r_out_red   <= '0;
                r_out_green <= '0;
                r_out_blue  <= '0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_status    = r_out_status;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_NXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, !o_ready)
    `ASSERT_IMP(a_status_no_color, i_clk, i_rst_n, o_valid && o_status,
        o_out_red == '0 && o_out_green == '0 && o_out_blue == '0)
    `ASSERT_IMP(a_taps_in_frame, i_clk, i_rst_n,
        (r_state == bir_pkg::S_RD00) || (r_state == bir_pkg::S_RD11),
        32'(r_x1) < 32'(w_use) && 32'(r_y1) < 32'(h_use) && r_x0 <= r_x1 && r_y0 <= r_y1)
    `ASSERT_NXT(a_write_in_range, i_clk, i_rst_n,
        in_xfer && (i_req_type == bir_pkg::REQ_WRITE) && wr_ok,
        r_state == bir_pkg::S_DONE && !r_status)

endmodule

### sim/bir_pixel_checker.sv
// ---------------------------------------------------------------------------
// bir_pixel_checker
// watches both channels and the config port of the bilinear resizer, keeps
// its own copy of the frame and settings, and compares every result transfer
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module bir_pixel_checker
    import bir_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic                  i_ready_in,
    input  logic                  i_req_type,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [CHAN_W-1:0]     i_in_red,
    input  logic [CHAN_W-1:0]     i_in_green,
    input  logic [CHAN_W-1:0]     i_in_blue,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [CHAN_W-1:0]     i_out_red,
    input  logic [CHAN_W-1:0]     i_out_green,
    input  logic [CHAN_W-1:0]     i_out_blue,
    input  logic                  i_out_status,
    output int                    o_mismatches,
    output int                    o_outstanding,
    output int                    o_resampled,
    output int                    o_stored,
    output int                    o_flagged
);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              status;
    } pixel_result_t;

    logic [3*CHAN_W-1:0]   frame_mirror [MAX_WIDTH*MAX_HEIGHT];
    logic [SIZE_REG_W-1:0] width_reg;
    logic [SIZE_REG_W-1:0] height_reg;
    logic [SCALE_W-1:0]    scale_x_reg;
    logic [SCALE_W-1:0]    scale_y_reg;
    pixel_result_t         expected_pixels [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        o_resampled   = 0;
        o_stored      = 0;
        o_flagged     = 0;
    end

    function automatic int unsigned size_in_use(logic [SIZE_REG_W-1:0] setting,
                                                int unsigned lim);
        if (setting == 0) return 1;
        if (setting > lim) return lim;
        return setting;
    endfunction

    // output coordinate to clamped source index and q16 fraction
    function automatic void map_to_source(input logic [POS_W-1:0] pos,
                                          input logic [SCALE_W-1:0] scale,
                                          input int unsigned size,
                                          output int unsigned idx,
                                          output longint unsigned frac);
        longint unsigned prod;
        longint unsigned whole;
        prod  = pos;
        prod  = prod * scale;
        whole = prod >> 16;
        if (whole > size - 1) begin
            idx  = size - 1;
            frac = 0;
        end else begin
            idx  = int'(whole);
            frac = prod & 64'hFFFF;
        end
    endfunction

    function automatic pixel_result_t predict_transfer(logic req,
                                                       logic [POS_W-1:0] px,
                                                       logic [POS_W-1:0] py,
                                                       logic [CHAN_W-1:0] r,
                                                       logic [CHAN_W-1:0] g,
                                                       logic [CHAN_W-1:0] b);
        pixel_result_t     res;
        int unsigned       w;
        int unsigned       h;
        int unsigned       x0;
        int unsigned       y0;
        int unsigned       x1;
        int unsigned       y1;
        longint unsigned   fx;
        longint unsigned   fy;
        longint unsigned   one;
        longint unsigned   wgt [4];
        logic [3*CHAN_W-1:0] tap [4];
        longint unsigned   acc;
        logic [CHAN_W-1:0] chan [3];
        res = '0;
        w   = size_in_use(width_reg, MAX_WIDTH);
        h   = size_in_use(height_reg, MAX_HEIGHT);
        if (req == REQ_WRITE) begin
            if (px >= w || py >= h) begin
                res.status = 1'b1;
            end else begin
                frame_mirror[int'(py) * MAX_WIDTH + int'(px)] = {r, g, b};
            end
            return res;
        end
        map_to_source(px, scale_x_reg, w, x0, fx);
        map_to_source(py, scale_y_reg, h, y0, fy);
        // right and lower taps stick to the last column and row
        x1  = (x0 + 1 < w) ? x0 + 1 : w - 1;
        y1  = (y0 + 1 < h) ? y0 + 1 : h - 1;
        one = ONE_Q16;
        wgt[0] = (one - fx) * (one - fy);
        wgt[1] = fx * (one - fy);
        wgt[2] = (one - fx) * fy;
        wgt[3] = fx * fy;
        tap[0] = frame_mirror[y0 * MAX_WIDTH + x0];
        tap[1] = frame_mirror[y0 * MAX_WIDTH + x1];
        tap[2] = frame_mirror[y1 * MAX_WIDTH + x0];
        tap[3] = frame_mirror[y1 * MAX_WIDTH + x1];
        for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) begin
                acc += wgt[k] * ((tap[k] >> (16 - 8 * ch)) & 24'hFF);
            end
            chan[ch] = 8'(acc >> 32);
        end
        res.red   = chan[0];
        res.green = chan[1];
        res.blue  = chan[2];
        return res;
    endfunction

    function automatic int field_mismatch(string name, logic [CHAN_W-1:0] want,
                                          logic [CHAN_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        pixel_result_t want;
        int            bad;
        if (!i_rst_n) begin
            width_reg   = SRC_WIDTH_RST;
            height_reg  = SRC_HEIGHT_RST;
            scale_x_reg = INV_SCALE_RST;
            scale_y_reg = INV_SCALE_RST;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SRC_WIDTH:   width_reg   = i_cfg_data[SIZE_REG_W-1:0];
                    CFG_SRC_HEIGHT:  height_reg  = i_cfg_data[SIZE_REG_W-1:0];
                    CFG_INV_SCALE_X: scale_x_reg = i_cfg_data[SCALE_W-1:0];
                    CFG_INV_SCALE_Y: scale_y_reg = i_cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            // results first: an item accepted now cannot answer at this edge
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result transfer with no pending expectation");
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    bad  = field_mismatch("out_red", want.red, i_out_red)
                         + field_mismatch("out_green", want.green, i_out_green)
                         + field_mismatch("out_blue", want.blue, i_out_blue)
                         + field_mismatch("status", {7'd0, want.status},
                                          {7'd0, i_out_status});
                    o_mismatches <= o_mismatches + bad;
                end
            end
            if (i_valid && i_ready_in) begin
                want = predict_transfer(i_req_type, i_pos_x, i_pos_y,
                                        i_in_red, i_in_green, i_in_blue);
                expected_pixels.push_back(want);
                if (i_req_type == REQ_READ) begin
                    o_resampled <= o_resampled + 1;
                end else if (want.status) begin
                    o_flagged <= o_flagged + 1;
                end else begin
                    o_stored <= o_stored + 1;
                end
            end
        end
        o_outstanding <= expected_pixels.size();
    end

endmodule

### sim/tb_bilinear_image_resize_top.sv
// ---------------------------------------------------------------------------
// tb_bilinear_image_resize_top
// drives frame writes and resample requests into the bilinear resizer under
// a range of sizes and scale factors, with bursty input and a stalling
// output; a side checker predicts and compares every result transfer
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bilinear_image_resize_top;
    import bir_pkg::*;

    localparam int MAX_WIDTH    = MAX_WIDTH_DEF;
    localparam int MAX_HEIGHT   = MAX_HEIGHT_DEF;
    // generous cap: roughly 7k items at worst-case gaps, stalls and hold-offs
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1000;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_req_type;
    logic [POS_W-1:0]      i_pos_x;
    logic [POS_W-1:0]      i_pos_y;
    logic [CHAN_W-1:0]     i_in_red;
    logic [CHAN_W-1:0]     i_in_green;
    logic [CHAN_W-1:0]     i_in_blue;
    logic                  o_valid;
    logic                  i_ready;
    logic [CHAN_W-1:0]     o_out_red;
    logic [CHAN_W-1:0]     o_out_green;
    logic [CHAN_W-1:0]     o_out_blue;
    logic                  o_status;

    int mismatches;
    int results_outstanding;
    int resampled_count;
    int stored_count;
    int flagged_count;

    // stimulus-side view of the active settings, used to keep requests on
    // written pixels and to aim coordinates near the edges
    int           eff_w;
    int           eff_h;
    logic [23:0]  scale_x_cfg;
    logic [23:0]  scale_y_cfg;
    int           settings_count;
    int           random_items;
    int           burst_left;
    int           hold_asked;
    int           hold_done;
    int           cycle_count;

    bilinear_image_resize_top #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_status    (o_status)
    );

    bir_pixel_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) pixel_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .i_ready_in    (o_ready),
        .i_req_type    (i_req_type),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_in_red      (i_in_red),
        .i_in_green    (i_in_green),
        .i_in_blue     (i_in_blue),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_red     (o_out_red),
        .i_out_green   (o_out_green),
        .i_out_blue    (o_out_blue),
        .i_out_status  (o_status),
        .o_mismatches  (mismatches),
        .o_outstanding (results_outstanding),
        .o_resampled   (resampled_count),
        .o_stored      (stored_count),
        .o_flagged     (flagged_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // size as the block uses it: zero means one, oversize saturates
    function automatic int active_size(int setting, int lim);
        if (setting == 0) return 1;
        return (setting > lim) ? lim : setting;
    endfunction

    // furthest output coordinate that still lands inside the source, plus a
    // little margin so the edge clamp gets hit too
    function automatic int coord_reach(int size, logic [23:0] scale);
        longint r;
        r = (longint'(size) << 16) / ((scale == 0) ? 1 : scale) + 2;
        return (r > POS_MAX) ? POS_MAX : int'(r);
    endfunction

    function automatic logic [23:0] pick_scale(int size);
        case ($urandom_range(0, 4))
            0: return 24'($urandom_range(1, 24'hFFFFFF));
            1: return 24'h010000;
            2: return 24'($urandom_range(0, 24'h030000));
            default: return 24'((size << 16) / $urandom_range(1, 64));
        endcase
    endfunction

    // mostly random levels, sometimes the rails
    function automatic logic [CHAN_W-1:0] pick_color();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom);
    endfunction

    // one input transfer; inside a burst valid stays high into the next item
    task automatic send_item(input logic req, input int x, input int y,
                             input logic [CHAN_W-1:0] r,
                             input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b);
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_pos_x    <= POS_W'(x);
        i_pos_y    <= POS_W'(y);
        i_in_red   <= r;
        i_in_green <= g;
        i_in_blue  <= b;
        do @(posedge i_clk); while (!o_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // close the stream and wait until every result has come back
    task automatic wait_for_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_outstanding != 0);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic write_settings(input int w_reg, input int h_reg,
                                  input logic [23:0] sx, input logic [23:0] sy);
        cfg_write(CFG_SRC_WIDTH, CFG_DATA_W'(w_reg & 10'h3FF));
        cfg_write(CFG_SRC_HEIGHT, CFG_DATA_W'(h_reg & 10'h3FF));
        cfg_write(CFG_INV_SCALE_X, sx);
        cfg_write(CFG_INV_SCALE_Y, sy);
        i_cfg_we    <= 1'b0;
        eff_w       = active_size(w_reg & 10'h3FF, MAX_WIDTH);
        eff_h       = active_size(h_reg & 10'h3FF, MAX_HEIGHT);
        scale_x_cfg = sx;
        scale_y_cfg = sy;
        settings_count++;
    endtask

    // random mix of requests, in-range writes and rejected writes
    task automatic random_mix(input int count);
        int sel;
        int x;
        int y;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                if ($urandom_range(0, 9) < 7) begin
                    x = $urandom_range(0, coord_reach(eff_w, scale_x_cfg));
                    y = $urandom_range(0, coord_reach(eff_h, scale_y_cfg));
                end else begin
                    x = $urandom_range(0, POS_MAX);
                    y = $urandom_range(0, POS_MAX);
                end
                send_item(REQ_READ, x, y, pick_color(), pick_color(), pick_color());
            end else if (sel < 85) begin
                send_item(REQ_WRITE, $urandom_range(0, eff_w - 1),
                          $urandom_range(0, eff_h - 1),
                          pick_color(), pick_color(), pick_color());
            end else begin
                // past the right edge, the bottom edge, or both
                if ($urandom_range(0, 1)) begin
                    x = $urandom_range(eff_w, POS_MAX);
                    y = $urandom_range(0, POS_MAX);
                end else begin
                    x = $urandom_range(0, POS_MAX);
                    y = $urandom_range(eff_h, POS_MAX);
                end
                send_item(REQ_WRITE, x, y, pick_color(), pick_color(), pick_color());
            end
            random_items++;
        end
    endtask

    // new settings, a full raster of the source, then random traffic
    task automatic run_setting(input int w_reg, input int h_reg,
                               input logic [23:0] sx, input logic [23:0] sy);
        wait_for_idle();
        write_settings(w_reg, h_reg, sx, sy);
        for (int y = 0; y < eff_h; y++) begin
            for (int x = 0; x < eff_w; x++) begin
                send_item(REQ_WRITE, x, y, pick_color(), pick_color(), pick_color());
            end
        end
        random_mix(80);
    endtask

    // output side: stall patterns in segments, plus requested long hold-offs
    initial begin
        int seg;
        int mode;
        i_ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(20, 200);
            repeat (seg) begin
                @(posedge i_clk);
                if (hold_asked != hold_done) begin
                    hold_done++;
                    i_ready <= 1'b0;
                    repeat (HOLD_CYCLES) begin
                        @(posedge i_clk);
                        i_ready <= 1'b0;
                    end
                end else begin
                    case (mode)
                        0: i_ready <= 1'b1;
                        1: i_ready <= ($urandom_range(0, 3) != 0);
                        2: i_ready <= ($urandom_range(0, 3) == 0);
                        default: i_ready <= ~i_ready;
                    endcase
                end
            end
        end
    end

    // input side and verdict
    initial begin
        int w_reg;
        int h_reg;
        hold_asked     = 0;
        hold_done      = 0;
        settings_count = 0;
        random_items   = 0;
        burst_left     = 0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_addr <= CFG_SRC_WIDTH;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_req_type <= REQ_WRITE;
        i_pos_x    <= '0;
        i_pos_y    <= '0;
        i_in_red   <= '0;
        i_in_green <= '0;
        i_in_blue  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 512 x 512 at 1/1.4; only the top-left 4 x 4 corner
        // gets written, and requests stay where they map into it
        eff_w       = MAX_WIDTH;
        eff_h       = MAX_HEIGHT;
        scale_x_cfg = INV_SCALE_RST;
        scale_y_cfg = INV_SCALE_RST;
        for (int y = 0; y < 4; y++) begin
            for (int x = 0; x < 4; x++) begin
                send_item(REQ_WRITE, x, y, 8'(x * 85), 8'(y * 85),
                          ((x ^ y) & 1) ? 8'hFF : 8'h00);
            end
        end
        // writes just past and far past the source are rejected
        send_item(REQ_WRITE, MAX_WIDTH, 0, 8'hFF, 8'hFF, 8'hFF);
        send_item(REQ_WRITE, 0, MAX_HEIGHT, 8'hFF, 8'hFF, 8'hFF);
        send_item(REQ_WRITE, POS_MAX, POS_MAX, 8'hFF, 8'h00, 8'hFF);
        send_item(REQ_WRITE, POS_MAX, 0, 8'h00, 8'hFF, 8'h00);
        send_item(REQ_READ, 0, 0, 8'h00, 8'h00, 8'h00);
        send_item(REQ_READ, 1, 0, 8'h00, 8'h00, 8'h00);
        send_item(REQ_READ, 0, 1, 8'h00, 8'h00, 8'h00);
        send_item(REQ_READ, 2, 3, 8'h00, 8'h00, 8'h00);
        send_item(REQ_READ, 4, 4, 8'h00, 8'h00, 8'h00);
        send_item(REQ_READ, 3, 1, 8'h00, 8'h00, 8'h00);

        // extreme settings: single pixel with huge and zero scale, zero size
        // registers, full-width single row, oversize registers, full-height
        // single column, then a moderate frame; the first one also gets a
        // long output hold-off so the block backs up
        hold_asked++;
        run_setting(1, 1, 24'hFFFFFF, 24'h000000);
        run_setting(0, 0, 24'h010000, 24'h010000);
        run_setting(MAX_WIDTH, 1, INV_SCALE_RST, 24'h000001);
        run_setting(1023, 2, 24'h008000, 24'hFFFFFF);
        run_setting(1, MAX_HEIGHT, 24'h000001, INV_SCALE_RST);
        run_setting(2, 513, 24'h010000, 24'h000000);
        run_setting(24, 16, INV_SCALE_RST, 24'h008000);

        // small random frames with random scales until enough traffic
        while (random_items < RANDOM_ITEMS) begin
            w_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            h_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            if ($urandom_range(0, 5) == 0) hold_asked++;
            run_setting(w_reg, h_reg, pick_scale(active_size(w_reg, MAX_WIDTH)),
                        pick_scale(active_size(h_reg, MAX_HEIGHT)));
        end

        wait_for_idle();
        repeat (20) @(posedge i_clk);

        $display("covered %0d resampled pixels, %0d stored writes, %0d rejected writes",
                 resampled_count, stored_count, flagged_count);
        $display("across %0d size and scale settings, zero, unit and full-range factors",
                 settings_count + 1);
        if (mismatches == 0 && results_outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
